/* src/wang_landau_ising_flip_step_defines.svh */
// ----------------------------------------------------------------------------
// Wang-Landau flip step: assertion macros
// Shared property wrappers for the checker. Each one samples on i_clk and is
// switched off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WANG_LANDAU_ISING_FLIP_STEP_DEFINES_SVH
`define WANG_LANDAU_ISING_FLIP_STEP_DEFINES_SVH

// Same-cycle implication.
`define WLFS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wlfs: same-cycle check failed");

// Next-cycle implication.
`define WLFS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wlfs: next-cycle check failed");

`endif

/* src/wlfs_pkg.sv */
// ----------------------------------------------------------------------------
// Wang-Landau flip step: package
// Widths, codes, state encoding and the level table entry shared by the
// interfaces, the top level and the checker.
// ----------------------------------------------------------------------------
package wlfs_pkg;

    // Default lattice side.
    localparam int unsigned LATTICE_SIDE_DEF = 32;

    // Fixed payload widths.
    localparam int unsigned LD_W   = 64;
    localparam int unsigned HIST_W = 32;
    localparam int unsigned LU_W   = 41;
    localparam int unsigned LOGF_W = 33;

    // Register port.
    localparam int unsigned APB_DATA_W = 64;
    localparam int unsigned APB_ADDR_W = 4;
    localparam logic        REG_IDX_LOG_F_STEP = 1'b0;
    localparam logic [LOGF_W-1:0] LOGF_RESET = 33'h1_0000_0000;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_WRITE_SPIN = 2'd0,
        REQ_SET_LEVEL  = 2'd1,
        REQ_FLIP       = 2'd2,
        REQ_READ       = 2'd3
    } t_req_type;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SIMPLE,
        ST_RD_ISSUE,
        ST_RD_DATA,
        ST_FL_A,
        ST_FL_B,
        ST_FL_C,
        ST_FL_SUM,
        ST_FL_DECIDE,
        ST_FL_UPDATE,
        ST_DONE
    } t_state;

    // One entry of the level memory.
    typedef struct packed {
        logic [LD_W-1:0]   ld;
        logic [HIST_W-1:0] hist;
    } t_lvl_entry;

    // Bits of a row or column index.
    function automatic int unsigned row_width(input int unsigned side);
        return $clog2(side);
    endfunction

    // Bits of an energy level, which runs from 0 to side*side.
    function automatic int unsigned level_width(input int unsigned side);
        return $clog2(side * side + 1);
    endfunction

endpackage

/* src/wlfs_ifs.sv */
// ----------------------------------------------------------------------------
// Wang-Landau flip step: stream interfaces
// Request and response channels, valid/ready, one word per handshake.
// ----------------------------------------------------------------------------
interface wlfs_req_if #(
    parameter int unsigned LATTICE_SIDE = wlfs_pkg::LATTICE_SIDE_DEF
);
    import wlfs_pkg::*;

    localparam int unsigned ROW_W = row_width(LATTICE_SIDE);
    localparam int unsigned LVL_W = level_width(LATTICE_SIDE);

    logic                    valid;
    logic                    ready;
    logic [1:0]              req_type;
    logic [ROW_W-1:0]        site_row;
    logic [ROW_W-1:0]        site_col;
    logic                    spin_up;
    logic [LVL_W-1:0]        level_index;
    logic signed [LU_W-1:0]  log_uniform;
    logic                    clear_hist;

    modport source (
        output valid, req_type, site_row, site_col, spin_up, level_index,
               log_uniform, clear_hist,
        input  ready
    );

    modport sink (
        input  valid, req_type, site_row, site_col, spin_up, level_index,
               log_uniform, clear_hist,
        output ready
    );
endinterface

interface wlfs_rsp_if #(
    parameter int unsigned LATTICE_SIDE = wlfs_pkg::LATTICE_SIDE_DEF
);
    import wlfs_pkg::*;

    localparam int unsigned LVL_W = level_width(LATTICE_SIDE);

    logic              valid;
    logic              ready;
    logic [LVL_W-1:0]  current_level_out;
    logic              accepted;
    logic [LD_W-1:0]   log_density_out;
    logic [HIST_W-1:0] hist_count_out;

    modport source (
        output valid, current_level_out, accepted, log_density_out, hist_count_out,
        input  ready
    );

    modport sink (
        input  valid, current_level_out, accepted, log_density_out, hist_count_out,
        output ready
    );
endinterface

/* src/wang_landau_ising_flip_step.sv */
// ----------------------------------------------------------------------------
// Wang-Landau Ising single-spin-flip step
// Holds a periodic LATTICE_SIDE x LATTICE_SIDE spin lattice in a spin memory
// and the log density and visit count of every energy level 0..side*side in a
// level memory, both synchronous with registered reads. Items are
// worked on one at a time by a sequencer that reads, modifies and writes back
// these memories. A spin write or level set passes through the simple state, a
// read issues one level memory read and takes its registered data, and a flip
// proposal reads the five spins over the two spin read ports in states FL_A to
// FL_C, and the current and proposed level entries over the single level read
// port, followed by a compare and a write-back step. A finished word waits
// in the output register while the next item is accepted. After reset a
// clearing pass zeroes every spin and all side*side+1 level entries before
// the first item is taken; register writes are taken throughout. log_f_step
// sits at byte address 0 of the 64-bit register port.
// ----------------------------------------------------------------------------
module wang_landau_ising_flip_step #(
    parameter int unsigned LATTICE_SIDE = wlfs_pkg::LATTICE_SIDE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wlfs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [wlfs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [wlfs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    wlfs_req_if.sink                          i_req,
    wlfs_rsp_if.source                        o_rsp
);
    import wlfs_pkg::*;

    localparam int unsigned ROW_W  = row_width(LATTICE_SIDE);
    localparam int unsigned LVL_W  = level_width(LATTICE_SIDE);
    localparam int unsigned SITES  = LATTICE_SIDE * LATTICE_SIDE;
    localparam int unsigned LEVELS = SITES + 1;
    localparam int unsigned SA_W   = $clog2(SITES);

    localparam logic [ROW_W:0]   SIDE_X  = (ROW_W+1)'(LATTICE_SIDE);
    localparam logic [ROW_W-1:0] SIDE_M1 = ROW_W'(LATTICE_SIDE - 1);
    localparam logic [LVL_W-1:0] MAX_LVL = LVL_W'(SITES);

    // Sequencer and configuration.
    t_state              r_state, n_state;
    logic [LVL_W-1:0]    r_clr_cnt;
    logic [LOGF_W-1:0]   r_log_f;
    logic [LVL_W-1:0]    r_cur_level;

    // Latched item.
    t_req_type               r_type;
    logic [ROW_W-1:0]        r_row, r_col;
    logic                    r_spin_up;
    logic [LVL_W-1:0]        r_level_idx;
    logic signed [LU_W-1:0]  r_lu;
    logic                    r_clr;

    // Flip working registers.
    logic                r_s_ctr;
    logic [2:0]          r_s_nb;
    t_lvl_entry          r_ent_cur, r_ent_prop;
    logic [LVL_W-1:0]    r_prop;
    logic                r_prop_ok;
    logic                r_acc;
    t_lvl_entry          r_res_ent;

    // Output register.
    logic                r_out_valid;
    logic [LVL_W-1:0]    r_out_level;
    logic                r_out_acc;
    t_lvl_entry          r_out_ent;

    // Memories and their ports.
    logic                r_spin_mem [SITES];
    logic                r_spin_q0, r_spin_q1;
    t_lvl_entry          r_lvl_mem [LEVELS];
    t_lvl_entry          r_lvl_q;

    logic                spin_we, spin_wd;
    logic [SA_W-1:0]     spin_wa, spin_ra0, spin_ra1;
    logic                lvl_we;
    logic [LVL_W-1:0]    lvl_wa, lvl_ra;
    t_lvl_entry          lvl_wd;
    logic                out_load;
    logic                in_ready;

    // Datapath helpers.
    logic [ROW_W:0]          row_ext, col_ext;
    logic [ROW_W-1:0]        row_wrap, col_wrap;
    logic [ROW_W-1:0]        row_up, row_dn, col_lf, col_rt;
    logic [2:0]              up_cnt;
    logic signed [3:0]       delta;
    logic signed [LVL_W+1:0] prop_wide;
    logic [LVL_W-1:0]        prop_lvl;
    logic                    prop_ok;
    logic signed [LD_W+1:0]  acc_lhs, acc_rhs;
    logic                    take;
    t_lvl_entry              upd_sel;
    logic [LD_W:0]           ld_sum;
    t_lvl_entry              upd_ent;
    logic                    rd_in_range;
    logic                    cfg_we;

    // Flat address of a lattice site.
    function automatic logic [SA_W-1:0] f_site(input logic [ROW_W-1:0] r,
                                               input logic [ROW_W-1:0] c);
        return SA_W'(SA_W'(r) * SA_W'(LATTICE_SIDE)) + SA_W'(c);
    endfunction

    // Register port: always ready, writes on the access phase.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_IDX_LOG_F_STEP);
    assign prdata = (paddr[APB_ADDR_W-1] == REG_IDX_LOG_F_STEP) ? APB_DATA_W'(r_log_f) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_f <= LOGF_RESET;
        end else if (cfg_we) begin
            r_log_f <= pwdata[LOGF_W-1:0];
        end
    end

    // Handshake and response ports.
    assign i_req.ready             = in_ready;
    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.current_level_out = r_out_level;
    assign o_rsp.accepted          = r_out_acc;
    assign o_rsp.log_density_out   = r_out_ent.ld;
    assign o_rsp.hist_count_out    = r_out_ent.hist;

    // Datapath arithmetic.
    always_comb begin
        // Incoming site folded into the lattice.
        row_ext  = {1'b0, ROW_W'(i_req.site_row)};
        col_ext  = {1'b0, ROW_W'(i_req.site_col)};
        row_wrap = (row_ext >= SIDE_X) ? ROW_W'(row_ext - SIDE_X) : row_ext[ROW_W-1:0];
        col_wrap = (col_ext >= SIDE_X) ? ROW_W'(col_ext - SIDE_X) : col_ext[ROW_W-1:0];

        // Wrapped neighbours of the latched site.
        row_up = (r_row == '0) ? SIDE_M1 : r_row - 1'b1;
        row_dn = (r_row == SIDE_M1) ? '0 : r_row + 1'b1;
        col_lf = (r_col == '0) ? SIDE_M1 : r_col - 1'b1;
        col_rt = (r_col == SIDE_M1) ? '0 : r_col + 1'b1;

        // Proposed level: current + spin * (up count - 2).
        up_cnt    = 3'(r_s_nb[0]) + 3'(r_s_nb[1]) + 3'(r_s_nb[2]) + 3'(r_spin_q0);
        delta     = r_s_ctr ? (signed'({1'b0, up_cnt}) - 4'sd2)
                            : (4'sd2 - signed'({1'b0, up_cnt}));
        prop_wide = signed'({2'b0, r_cur_level}) + (LVL_W+2)'(delta);
        prop_ok   = !prop_wide[LVL_W+1] && (prop_wide[LVL_W:0] <= {1'b0, MAX_LVL});
        prop_lvl  = prop_wide[LVL_W-1:0];

        // Acceptance: log_uniform + ld[proposed] < ld[current].
        acc_lhs = signed'((LD_W+2)'(r_lu)) + signed'({2'b0, r_lvl_q.ld});
        acc_rhs = signed'({2'b0, r_ent_cur.ld});
        take    = r_prop_ok && (acc_lhs < acc_rhs);

        // Saturating update of the level that ends up current.
        upd_sel      = r_acc ? r_ent_prop : r_ent_cur;
        ld_sum       = {1'b0, upd_sel.ld} + (LD_W+1)'(r_log_f);
        upd_ent.ld   = ld_sum[LD_W] ? '1 : ld_sum[LD_W-1:0];
        upd_ent.hist = (&upd_sel.hist) ? upd_sel.hist : upd_sel.hist + 1'b1;

        rd_in_range = (r_level_idx <= MAX_LVL);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_cnt == MAX_LVL) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    case (t_req_type'(i_req.req_type))
                        REQ_FLIP: n_state = ST_FL_A;
                        REQ_READ: n_state = ST_RD_ISSUE;
                        default:  n_state = ST_SIMPLE;
                    endcase
                end
            end
            ST_SIMPLE:    n_state = ST_DONE;
            ST_RD_ISSUE:  n_state = ST_RD_DATA;
            ST_RD_DATA:   n_state = ST_DONE;
            ST_FL_A:      n_state = ST_FL_B;
            ST_FL_B:      n_state = ST_FL_C;
            ST_FL_C:      n_state = ST_FL_SUM;
            ST_FL_SUM:    n_state = ST_FL_DECIDE;
            ST_FL_DECIDE: n_state = ST_FL_UPDATE;
            ST_FL_UPDATE: n_state = ST_DONE;
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Memory control and handshake outputs.
    always_comb begin
        in_ready = 1'b0;
        out_load = 1'b0;
        spin_we  = 1'b0;
        spin_wa  = f_site(r_row, r_col);
        spin_wd  = r_spin_up;
        spin_ra0 = f_site(r_row, r_col);
        spin_ra1 = f_site(row_up, r_col);
        lvl_we   = 1'b0;
        lvl_wa   = r_cur_level;
        lvl_wd   = upd_ent;
        lvl_ra   = r_cur_level;
        case (r_state)
            ST_CLEAR: begin
                spin_we = (r_clr_cnt < MAX_LVL);
                spin_wa = r_clr_cnt[SA_W-1:0];
                spin_wd = 1'b0;
                lvl_we  = 1'b1;
                lvl_wa  = r_clr_cnt;
                lvl_wd  = '0;
            end
            ST_IDLE: begin
                in_ready = 1'b1;
            end
            ST_SIMPLE: begin
                spin_we = (r_type == REQ_WRITE_SPIN);
            end
            ST_RD_ISSUE: begin
                lvl_ra = rd_in_range ? r_level_idx : '0;
            end
            ST_RD_DATA: begin
                lvl_we      = rd_in_range && r_clr;
                lvl_wa      = r_level_idx;
                lvl_wd.ld   = r_lvl_q.ld;
                lvl_wd.hist = '0;
            end
            ST_FL_A: begin
                spin_ra0 = f_site(r_row, r_col);
                spin_ra1 = f_site(row_up, r_col);
                lvl_ra   = r_cur_level;
            end
            ST_FL_B: begin
                spin_ra0 = f_site(row_dn, r_col);
                spin_ra1 = f_site(r_row, col_lf);
            end
            ST_FL_C: begin
                spin_ra0 = f_site(r_row, col_rt);
                spin_ra1 = f_site(r_row, col_rt);
            end
            ST_FL_SUM: begin
                lvl_ra = prop_ok ? prop_lvl : r_cur_level;
            end
            ST_FL_UPDATE: begin
                spin_we = r_acc;
                spin_wd = !r_s_ctr;
                lvl_we  = 1'b1;
                lvl_wa  = r_acc ? r_prop : r_cur_level;
            end
            ST_DONE: begin
                out_load = !r_out_valid || o_rsp.ready;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Spin memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (spin_we) begin
            r_spin_mem[spin_wa] <= spin_wd;
        end
        r_spin_q0 <= r_spin_mem[spin_ra0];
        r_spin_q1 <= r_spin_mem[spin_ra1];
    end

    // Level memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            r_lvl_mem[lvl_wa] <= lvl_wd;
        end
        r_lvl_q <= r_lvl_mem[lvl_ra];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_cur_level <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (r_state == ST_SIMPLE && r_type == REQ_SET_LEVEL && rd_in_range) begin
                r_cur_level <= r_level_idx;
            end else if (r_state == ST_FL_UPDATE && r_acc) begin
                r_cur_level <= r_prop;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item and working registers.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_req.valid) begin
            r_type      <= t_req_type'(i_req.req_type);
            r_row       <= row_wrap;
            r_col       <= col_wrap;
            r_spin_up   <= i_req.spin_up;
            r_level_idx <= i_req.level_index;
            r_lu        <= i_req.log_uniform;
            r_clr       <= i_req.clear_hist;
            r_acc       <= 1'b0;
            r_res_ent   <= '0;
        end
        case (r_state)
            ST_RD_DATA: begin
                if (rd_in_range) begin
                    r_res_ent <= r_lvl_q;
                end
            end
            ST_FL_B: begin
                r_s_ctr   <= r_spin_q0;
                r_s_nb[0] <= r_spin_q1;
                r_ent_cur <= r_lvl_q;
            end
            ST_FL_C: begin
                r_s_nb[1] <= r_spin_q0;
                r_s_nb[2] <= r_spin_q1;
            end
            ST_FL_SUM: begin
                r_prop    <= prop_lvl;
                r_prop_ok <= prop_ok;
            end
            ST_FL_DECIDE: begin
                r_ent_prop <= r_lvl_q;
                r_acc      <= take;
            end
            default: begin
                r_prop_ok <= r_prop_ok;
            end
        endcase
        if (out_load) begin
            r_out_level <= (r_state == ST_DONE) ? r_cur_level : r_out_level;
            r_out_acc   <= r_acc;
            r_out_ent   <= r_res_ent;
        end
    end

endmodule

/* src/wlfs_checker.sv */
// ----------------------------------------------------------------------------
// Wang-Landau flip step: port checker
// Watches the stream ports of the top level and flags behaviour that the
// sequencer must never show.
// ----------------------------------------------------------------------------
`include "wang_landau_ising_flip_step_defines.svh"

module wlfs_checker #(
    parameter int unsigned LATTICE_SIDE = wlfs_pkg::LATTICE_SIDE_DEF
) (
    input logic                                              i_clk,
    input logic                                              i_rst_n,
    input logic                                              i_req_valid,
    input logic                                              i_req_ready,
    input logic                                              i_rsp_valid,
    input logic                                              i_rsp_ready,
    input logic [wlfs_pkg::level_width(LATTICE_SIDE)-1:0]    i_rsp_level,
    input logic                                              i_rsp_accepted,
    input logic [wlfs_pkg::LD_W-1:0]                         i_rsp_ld,
    input logic [wlfs_pkg::HIST_W-1:0]                       i_rsp_hist
);
    import wlfs_pkg::*;

    localparam int unsigned LVL_W = level_width(LATTICE_SIDE);
    localparam logic [LVL_W-1:0] MAX_LVL = LVL_W'(LATTICE_SIDE * LATTICE_SIDE);

    // A stalled response word holds.
    `WLFS_ASSERT_NXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_level) && $stable(i_rsp_accepted) && $stable(i_rsp_ld) && $stable(i_rsp_hist))

    // Items are worked on one at a time, so ready drops after an accept.
    `WLFS_ASSERT_NXT(a_one_at_a_time, i_req_valid && i_req_ready, !i_req_ready)

    // The current level never leaves the level range.
    `WLFS_ASSERT_IMP(a_level_range, i_rsp_valid, i_rsp_level <= MAX_LVL)

    // An accepted flip is not a read, so its read fields are zero.
    `WLFS_ASSERT_IMP(a_flip_no_read, i_rsp_valid && i_rsp_accepted, (i_rsp_ld == '0) && (i_rsp_hist == '0))

endmodule

bind wang_landau_ising_flip_step wlfs_checker #(
    .LATTICE_SIDE (LATTICE_SIDE)
) u_wlfs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_level    (o_rsp.current_level_out),
    .i_rsp_accepted (o_rsp.accepted),
    .i_rsp_ld       (o_rsp.log_density_out),
    .i_rsp_hist     (o_rsp.hist_count_out)
);
